### sv/assert_macros.svh
// Assertion macros used by the raycaster back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables it and a fixed message.
`define GRC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("raycaster assertion failed");

// Clocked property with a reset that disables it and a message of its own.
`define GRC_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

`endif

### sv/grc_pkg.sv
`timescale 1ns / 1ps
package grc_pkg;

	localparam int MAP_SIZE    = 32;
	localparam int MAP_AW      = $clog2(MAP_SIZE);
	localparam int MAX_DEPTH   = 16;
	localparam int DEPTH       = MAX_DEPTH * 256;
	localparam int MARCH_STEP  = 26;
	localparam int EDGE_RATIO  = 10000;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int DIV_NW      = 22;
	localparam int DIV_DW      = 14;

	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [30:0] C3 = 31'd693598668;
	localparam logic [30:0] C5 = 31'd85569306;
	localparam logic [30:0] C7 = 31'd5026995;
	localparam logic [30:0] C9 = 31'd172272;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_CAST = 1'b1;

	localparam logic [2:0] CFG_PLAYER_X  = 3'd0;
	localparam logic [2:0] CFG_PLAYER_Y  = 3'd1;
	localparam logic [2:0] CFG_HEADING   = 3'd2;
	localparam logic [2:0] CFG_FOV       = 3'd3;
	localparam logic [2:0] CFG_WIDTH     = 3'd4;
	localparam logic [2:0] CFG_HEIGHT    = 3'd5;

	localparam logic [2:0] SHADE_FULL   = 3'd0;
	localparam logic [2:0] SHADE_DARK   = 3'd1;
	localparam logic [2:0] SHADE_MEDIUM = 3'd2;
	localparam logic [2:0] SHADE_LIGHT  = 3'd3;
	localparam logic [2:0] SHADE_BLANK  = 3'd4;

	typedef struct packed {
		logic [12:0] player_x;
		logic [12:0] player_y;
		logic [11:0] player_heading;
		logic [11:0] field_of_view;
		logic [9:0]  screen_width;
		logic [9:0]  screen_height;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  row_index;
		logic [31:0] row_bits;
		logic [9:0]  column;
	} cmd_t;

	typedef struct packed {
		logic [9:0]         column_out;
		logic [12:0]        distance;
		logic signed [10:0] ceiling_row;
		logic [10:0]        floor_row;
		logic [2:0]         wall_shade;
		logic               tile_edge;
	} res_t;

	typedef struct packed {
		logic              kind;
		logic [4:0]        row_index;
		logic [31:0]       row_bits;
		logic [9:0]        column;
		logic [DIV_NW-1:0] cprod;
	} qent_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	function automatic logic [30:0] horner_coef(input logic [1:0] k);
		logic [30:0] c;
		unique case (k)
			2'd0: c = C7;
			2'd1: c = C5;
			2'd2: c = C3;
			default: c = C1;
		endcase
		return c;
	endfunction

endpackage

### sv/grc_div.sv
`timescale 1ns / 1ps
module grc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  grc_pkg::div_req_t   req,
	output grc_pkg::div_rsp_t   rsp
);

	logic [grc_pkg::DIV_DW:0]      rem_q;
	logic [grc_pkg::DIV_NW-1:0]    nq_q;
	logic [grc_pkg::DIV_DW-1:0]    den_q;
	logic [$clog2(grc_pkg::DIV_NW+1)-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [grc_pkg::DIV_DW:0]      rem_sh;
	logic                          fits;

	assign rem_sh = {rem_q[grc_pkg::DIV_DW-1:0], nq_q[grc_pkg::DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(grc_pkg::DIV_NW+1))'(grc_pkg::DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			nq_q  <= {nq_q[grc_pkg::DIV_NW-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = nq_q;

endmodule

### sv/grc_queue.sv
`timescale 1ns / 1ps
module grc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  grc_pkg::qent_t din,
	input  logic           pop,
	output grc_pkg::qent_t dout,
	output logic           empty,
	output logic           full
);

	grc_pkg::qent_t           buf_q [grc_pkg::QDEPTH];
	logic [grc_pkg::QAW-1:0]  head_q;
	logic [grc_pkg::QAW-1:0]  tail_q;
	logic [grc_pkg::QAW:0]    count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (grc_pkg::QAW+1)'(grc_pkg::QDEPTH);
	assign dout  = buf_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) tail_q <= tail_q + 1'b1;
			if (pop) head_q <= head_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[tail_q] <= din;
	end

endmodule

### sv/grc_front.sv
`timescale 1ns / 1ps
module grc_front (
	input  logic           cmd_valid,
	input  grc_pkg::cmd_t  cmd,
	output logic           cmd_stall,
	input  grc_pkg::cfg_t  cfg,
	input  logic           q_full,
	output logic           push,
	output grc_pkg::qent_t ent
);

	logic keep;

	// A map row beyond the map is dropped here and never reaches the back end.
	assign keep      = (cmd.kind == grc_pkg::KIND_CAST) || (32'(cmd.row_index) < grc_pkg::MAP_SIZE);
	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full && keep;

	always_comb begin
		ent.kind      = cmd.kind;
		ent.row_index = cmd.row_index;
		ent.row_bits  = cmd.row_bits;
		ent.column    = cmd.column;
		ent.cprod     = grc_pkg::DIV_NW'(cmd.column) * grc_pkg::DIV_NW'(cfg.field_of_view);
	end

endmodule

### sv/grc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  grc_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  grc_pkg::qent_t q_head,
	output logic           q_pop,
	output logic           res_valid,
	output grc_pkg::res_t  res,
	input  logic           res_stall
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_ANG   = 5'd1;
	localparam logic [4:0] S_TINIT = 5'd2;
	localparam logic [4:0] S_TMUL  = 5'd3;
	localparam logic [4:0] S_TSUB  = 5'd4;
	localparam logic [4:0] S_TFMUL = 5'd5;
	localparam logic [4:0] S_TFIN  = 5'd6;
	localparam logic [4:0] S_MSTEP = 5'd7;
	localparam logic [4:0] S_MREAD = 5'd8;
	localparam logic [4:0] S_EV    = 5'd9;
	localparam logic [4:0] S_ESQX  = 5'd10;
	localparam logic [4:0] S_ESQY  = 5'd11;
	localparam logic [4:0] S_ESUM  = 5'd12;
	localparam logic [4:0] S_BV    = 5'd13;
	localparam logic [4:0] S_BM1   = 5'd14;
	localparam logic [4:0] S_BM2   = 5'd15;
	localparam logic [4:0] S_BM3   = 5'd16;
	localparam logic [4:0] S_BM4   = 5'd17;
	localparam logic [4:0] S_BM5   = 5'd18;
	localparam logic [4:0] S_BM6   = 5'd19;
	localparam logic [4:0] S_BCHK  = 5'd20;
	localparam logic [4:0] S_CEIL  = 5'd21;
	localparam logic [4:0] S_CDIV  = 5'd22;
	localparam logic [4:0] S_CWAIT = 5'd23;
	localparam logic [4:0] S_DONE  = 5'd24;

	logic [4:0]          state_q;
	logic [4:0]          state_d;
	logic                rv_q;
	grc_pkg::res_t       res_q;

	logic [31:0]         map_mem [grc_pkg::MAP_SIZE];
	logic [grc_pkg::MAP_SIZE-1:0] map_v_q;
	logic [31:0]         row_q;
	logic                rowv_q;

	grc_pkg::div_req_t   div_req;
	grc_pkg::div_rsp_t   div_rsp;

	logic signed [36:0]  ma;
	logic signed [32:0]  mb;
	logic signed [69:0]  prod_q;

	logic [9:0]          col_q;
	logic [11:0]         ang_q;
	logic                sel_q;
	logic [1:0]          k_q;
	logic [10:0]         rr_q;
	logic [30:0]         x2_q;
	logic [30:0]         p_q;
	logic signed [15:0]  ex_q;
	logic signed [15:0]  ey_q;
	logic [12:0]         d_q;
	logic signed [28:0]  px_q;
	logic signed [28:0]  py_q;
	logic [6:0]          cx_q;
	logic [6:0]          cy_q;
	logic [1:0]          c_q;
	logic [1:0]          far_q;
	logic [27:0]         v2_q [4];
	logic [27:0]         v2far_q;
	logic signed [14:0]  vx_q;
	logic signed [14:0]  vy_q;
	logic signed [31:0]  acc_q;
	logic                dotpos_q;
	logic [17:0]         mag_q;
	logic                big_q;
	logic                edge_q;
	logic signed [10:0]  ceil_q;
	logic [10:0]         floor_q;
	logic [2:0]          shade_q;

	logic [11:0]         tang;
	logic [10:0]         rr_c;
	logic [32:0]         s_c;
	logic [32:0]         sr_c;
	logic [14:0]         mv_c;
	logic signed [15:0]  trig_c;
	logic signed [20:0]  stx_c;
	logic signed [20:0]  sty_c;
	logic [12:0]         dn_c;
	logic signed [28:0]  pxn_c;
	logic signed [28:0]  pyn_c;
	logic                outside_c;
	logic                wall_c;
	logic signed [14:0]  vx_c;
	logic signed [14:0]  vy_c;
	logic [27:0]         v2_c;
	logic signed [31:0]  cr_c;
	logic [31:0]         crm_c;
	logic [31:0]         sh_c;
	logic [9:0]          w_c;
	logic [12:0]         dcap_c;
	logic [21:0]         cnum_c;
	logic                graze_c;
	logic [2:0]          shade_c;
	logic [11:0]         angn_c;

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign res_valid = rv_q;
	assign res       = res_q;

	// Trigonometry on the quarter wave.
	assign tang  = sel_q ? ang_q + 12'd1024 : ang_q;
	assign rr_c  = tang[10] ? 11'd1024 - {1'b0, tang[9:0]} : {1'b0, tang[9:0]};
	assign s_c   = prod_q[42:10];
	assign sr_c  = s_c + 33'd32768;
	assign mv_c  = (sr_c[32:16] > 17'd16384) ? 15'd16384 : sr_c[30:16];
	assign trig_c = tang[11] ? -$signed({1'b0, mv_c}) : $signed({1'b0, mv_c});

	// March step.
	assign stx_c = 21'(ex_q) * 21'sd26;
	assign sty_c = 21'(ey_q) * 21'sd26;
	assign dn_c  = d_q + 13'(grc_pkg::MARCH_STEP);
	assign pxn_c = px_q + 29'(stx_c);
	assign pyn_c = py_q + 29'(sty_c);
	assign outside_c = pxn_c[28] || pyn_c[28]
		|| (32'(pxn_c[28:22]) >= grc_pkg::MAP_SIZE)
		|| (32'(pyn_c[28:22]) >= grc_pkg::MAP_SIZE);
	assign wall_c = rowv_q && (cy_q < 7'd32) && row_q[cy_q[4:0]];

	// Corner vectors of the hit cell.
	assign vx_c = $signed({1'b0, 6'(cx_q[5:0] + {5'b0, c_q[1]}), 8'h00})
		- $signed({2'b00, cfg.player_x});
	assign vy_c = $signed({1'b0, 6'(cy_q[5:0] + {5'b0, c_q[0]}), 8'h00})
		- $signed({2'b00, cfg.player_y});
	assign v2_c = acc_q[27:0] + prod_q[27:0];
	assign cr_c = acc_q - $signed(prod_q[31:0]);
	assign crm_c = cr_c[31] ? 32'(-cr_c) : 32'(cr_c);
	assign sh_c = crm_c >> 4;
	assign graze_c = dotpos_q && !big_q && (v2_q[c_q] != '0)
		&& (prod_q[49:0] < {2'b00, v2_q[c_q], 20'h00000});

	assign w_c    = (cfg.screen_width == '0) ? 10'd1 : cfg.screen_width;
	assign dcap_c = (d_q > 13'(grc_pkg::DEPTH)) ? 13'(grc_pkg::DEPTH) : d_q;
	assign cnum_c = (d_q >= 13'd512)
		? 22'(cfg.screen_height) * 22'(d_q - 13'd512)
		: 22'(cfg.screen_height) * 22'(13'd512 - d_q);
	assign angn_c = cfg.player_heading + div_rsp.quo[11:0] - (cfg.field_of_view >> 1);

	always_comb begin
		if ({d_q, 2'b00} <= 15'(grc_pkg::DEPTH)) shade_c = grc_pkg::SHADE_FULL;
		else if (15'(d_q) * 15'd3 < 15'(grc_pkg::DEPTH)) shade_c = grc_pkg::SHADE_DARK;
		else if ({d_q, 1'b0} < 14'(grc_pkg::DEPTH)) shade_c = grc_pkg::SHADE_MEDIUM;
		else if (d_q < 13'(grc_pkg::DEPTH)) shade_c = grc_pkg::SHADE_LIGHT;
		else shade_c = grc_pkg::SHADE_BLANK;
		if (edge_q) shade_c = grc_pkg::SHADE_BLANK;
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = q_head.cprod;
		div_req.den   = 14'(w_c);
		if (q_pop && q_head.kind == grc_pkg::KIND_CAST) begin
			div_req.start = 1'b1;
		end else if (state_q == S_CDIV) begin
			div_req.start = 1'b1;
			div_req.num   = cnum_c;
			div_req.den   = {d_q, 1'b0};
		end
	end

	// A multiplier shared by the sine and corner-test states, its product registered.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_TMUL: begin
				ma = $signed({6'b0, x2_q});
				mb = $signed({2'b0, p_q});
			end
			S_TFMUL: begin
				ma = $signed({26'b0, rr_q});
				mb = $signed({2'b0, p_q});
			end
			S_ESQX: begin
				ma = 37'(vx_q);
				mb = 33'(vx_q);
			end
			S_ESQY: begin
				ma = 37'(vy_q);
				mb = 33'(vy_q);
			end
			S_BM1: begin
				ma = 37'(ex_q);
				mb = 33'(vx_q);
			end
			S_BM2: begin
				ma = 37'(ey_q);
				mb = 33'(vy_q);
			end
			S_BM3: begin
				ma = 37'(ex_q);
				mb = 33'(vy_q);
			end
			S_BM4: begin
				ma = 37'(ey_q);
				mb = 33'(vx_q);
			end
			S_BM5: begin
				ma = $signed({19'b0, sh_c[17:0]});
				mb = 33'(grc_pkg::EDGE_RATIO);
			end
			S_BM6: begin
				ma = $signed({5'b0, prod_q[31:0]});
				mb = $signed({15'b0, mag_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (q_pop && q_head.kind == grc_pkg::KIND_CAST) state_d = S_ANG;
			S_ANG: if (div_rsp.done) state_d = S_TINIT;
			S_TINIT: state_d = S_TMUL;
			S_TMUL: state_d = S_TSUB;
			S_TSUB: state_d = (k_q == 2'd3) ? S_TFMUL : S_TMUL;
			S_TFMUL: state_d = S_TFIN;
			S_TFIN: state_d = sel_q ? S_MSTEP : S_TINIT;
			S_MSTEP: begin
				if (d_q >= 13'(grc_pkg::DEPTH) || outside_c) state_d = S_CEIL;
				else state_d = S_MREAD;
			end
			S_MREAD: state_d = wall_c ? S_EV : S_MSTEP;
			S_EV: state_d = S_ESQX;
			S_ESQX: state_d = S_ESQY;
			S_ESQY: state_d = S_ESUM;
			S_ESUM: state_d = (c_q == 2'd3) ? S_BV : S_EV;
			S_BV: begin
				if (c_q != far_q) state_d = S_BM1;
				else if (c_q == 2'd3) state_d = S_CEIL;
			end
			S_BM1: state_d = S_BM2;
			S_BM2: state_d = S_BM3;
			S_BM3: state_d = S_BM4;
			S_BM4: state_d = S_BM5;
			S_BM5: state_d = S_BM6;
			S_BM6: state_d = S_BCHK;
			S_BCHK: state_d = (c_q == 2'd3) ? S_CEIL : S_BV;
			S_CEIL: state_d = S_CDIV;
			S_CDIV: state_d = S_CWAIT;
			S_CWAIT: if (div_rsp.done) state_d = S_DONE;
			S_DONE: if (!rv_q || !res_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
			map_v_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!rv_q || !res_stall)) rv_q <= 1'b1;
			else if (!res_stall) rv_q <= 1'b0;
			if (q_pop && q_head.kind == grc_pkg::KIND_LOAD) begin
				map_v_q[q_head.row_index[grc_pkg::MAP_AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == grc_pkg::KIND_LOAD) begin
			map_mem[q_head.row_index[grc_pkg::MAP_AW-1:0]] <= q_head.row_bits;
		end
		if (state_q == S_MSTEP) begin
			row_q  <= map_mem[pxn_c[22+grc_pkg::MAP_AW-1:22]];
			rowv_q <= map_v_q[pxn_c[22+grc_pkg::MAP_AW-1:22]];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 70'(ma) * 70'(mb);
		unique case (state_q)
			S_IDLE: begin
				col_q <= q_head.column;
				sel_q <= 1'b0;
			end
			S_ANG: ang_q <= angn_c;
			S_TINIT: begin
				rr_q <= rr_c;
				x2_q <= 31'({22'(rr_c) * 22'(rr_c), 10'b0});
				p_q  <= grc_pkg::C9;
				k_q  <= 2'd0;
			end
			S_TSUB: begin
				p_q <= grc_pkg::horner_coef(k_q) - prod_q[60:30];
				k_q <= k_q + 1'b1;
			end
			S_TFIN: begin
				if (sel_q) begin
					ey_q   <= trig_c;
					px_q   <= $signed({2'b00, cfg.player_x, 14'h0000});
					py_q   <= $signed({2'b00, cfg.player_y, 14'h0000});
					d_q    <= '0;
					edge_q <= 1'b0;
				end else begin
					ex_q <= trig_c;
				end
				sel_q <= 1'b1;
			end
			S_MSTEP: begin
				if (d_q < 13'(grc_pkg::DEPTH)) begin
					d_q  <= outside_c ? 13'(grc_pkg::DEPTH) : dn_c;
					px_q <= pxn_c;
					py_q <= pyn_c;
					cx_q <= pxn_c[28:22];
					cy_q <= pyn_c[28:22];
				end
			end
			S_MREAD: begin
				c_q <= 2'd0;
			end
			S_EV: begin
				vx_q <= vx_c;
				vy_q <= vy_c;
			end
			S_ESQY: acc_q <= prod_q[31:0];
			S_ESUM: begin
				v2_q[c_q] <= v2_c;
				if (c_q == 2'd0 || v2_c >= v2far_q) begin
					far_q   <= c_q;
					v2far_q <= v2_c;
				end
				c_q <= c_q + 1'b1;
			end
			S_BV: begin
				vx_q <= vx_c;
				vy_q <= vy_c;
				if (c_q == far_q) c_q <= c_q + 1'b1;
			end
			S_BM2: acc_q <= prod_q[31:0];
			S_BM3: dotpos_q <= (acc_q + $signed(prod_q[31:0])) > 32'sd0;
			S_BM4: acc_q <= prod_q[31:0];
			S_BM5: begin
				mag_q <= sh_c[17:0];
				big_q <= |sh_c[31:18];
			end
			S_BCHK: begin
				if (graze_c) edge_q <= 1'b1;
				c_q <= c_q + 1'b1;
			end
			S_CEIL: d_q <= dcap_c;
			S_CWAIT: begin
				if (d_q >= 13'd512) ceil_q <= $signed(div_rsp.quo[10:0]);
				else ceil_q <= (div_rsp.quo == '0) ? 11'sd0 : -11'sd1;
				shade_q <= shade_c;
			end
			S_DONE: begin
				if (!rv_q || !res_stall) begin
					res_q.column_out  <= col_q;
					res_q.distance    <= d_q;
					res_q.ceiling_row <= ceil_q;
					res_q.floor_row   <= 11'(cfg.screen_height) - 11'(ceil_q);
					res_q.wall_shade  <= shade_q;
					res_q.tile_edge   <= edge_q;
				end
			end
			default: begin
			end
		endcase
	end

	`GRC_ASSERT(a_div_free, clk, arst_n, div_req.start |-> !div_rsp.busy)
	`GRC_ASSERT(a_depth_bound, clk, arst_n, (state_q == S_MREAD) |-> d_q <= 13'(grc_pkg::DEPTH + grc_pkg::MARCH_STEP))
	`GRC_ASSERT_MSG(a_res_source, clk, arst_n, $rose(rv_q) |-> $past(state_q) == S_DONE, "result word raised outside finish")

endmodule

### sv/grid_raycast_column_unit.sv
`timescale 1ns / 1ps
// Port group  Handshake               Word
// cmd         cmd_valid / cmd_stall   grc_pkg::cmd_t (map row load or column cast)
// res         res_valid / res_stall   grc_pkg::res_t (one per cast)
// cfg         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A map row load is written to the back end's map as it leaves the queue. A cast's time is
// set by the sequential march (up to 158 steps), the corner test when the ray meets a wall,
// and the divider, used for the angle and again for the ceiling row.
// Reset loads the default view and marks every map row clear through per-row flags.
// A four-word queue lets the front keep accepting while the back end works or stalls.
module grid_raycast_column_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  grc_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output grc_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	grc_pkg::cfg_t  cfg_q;
	grc_pkg::qent_t ent;
	grc_pkg::qent_t q_head;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x       <= 13'd3763;
			cfg_q.player_y       <= 13'd1303;
			cfg_q.player_heading <= 12'd0;
			cfg_q.field_of_view  <= 12'd512;
			cfg_q.screen_width   <= 10'd320;
			cfg_q.screen_height  <= 10'd240;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				grc_pkg::CFG_PLAYER_X: cfg_q.player_x <= cfg_data[12:0];
				grc_pkg::CFG_PLAYER_Y: cfg_q.player_y <= cfg_data[12:0];
				grc_pkg::CFG_HEADING: cfg_q.player_heading <= cfg_data[11:0];
				grc_pkg::CFG_FOV: cfg_q.field_of_view <= cfg_data[11:0];
				grc_pkg::CFG_WIDTH: cfg_q.screen_width <= cfg_data[9:0];
				grc_pkg::CFG_HEIGHT: cfg_q.screen_height <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	grc_front u_front (
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.ent       (ent)
	);

	grc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (ent),
		.pop    (pop),
		.dout   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	grc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (pop),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE      = 700;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	grc_pkg::cmd_t cmd;
	logic res_valid;
	logic res_stall;
	grc_pkg::res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	grid_raycast_column_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [31:0] map_rows [grc_pkg::MAP_SIZE];
	int unsigned view_x, view_y, view_heading, view_fov, view_width, view_height;

	grc_pkg::res_t column_q [$];
	int errors;
	int casts_seen;
	int words_sent;
	int cycles;
	bit quiet;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint sine_quarter(int unsigned r);
		longint unsigned x, x2, p, s, q;
		x  = longint'(r) << 20;
		x2 = (x * x) >> 30;
		p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
		p  = 64'd85569306 - ((x2 * p) >> 30);
		p  = 64'd693598668 - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		s  = (x * p) >> 30;
		q  = (s + 64'd32768) >> 16;
		if (q > 16384)
			q = 16384;
		return longint'(q);
	endfunction

	function automatic longint sine_lookup(int unsigned a);
		int unsigned qd, r;
		longint m;
		qd = (a >> 10) & 3;
		r  = a & 1023;
		m  = qd[0] ? sine_quarter(1024 - r) : sine_quarter(r);
		return qd[1] ? -m : m;
	endfunction

	function automatic bit grazes_corner(longint cx, longint cy, longint ex, longint ey);
		longint vx [4];
		longint vy [4];
		longint unsigned v2 [4];
		longint dotp, cr;
		longint unsigned mag;
		int far_c;
		bit hit_edge;
		far_c = 0;
		hit_edge = 1'b0;
		for (int c = 0; c < 4; c++) begin
			vx[c] = (cx + (c >> 1)) * 256 - longint'(view_x);
			vy[c] = (cy + (c & 1)) * 256 - longint'(view_y);
			v2[c] = longint'(vx[c] * vx[c] + vy[c] * vy[c]);
			if (v2[c] >= v2[far_c])
				far_c = c;
		end
		for (int c = 0; c < 4; c++) begin
			if (c != far_c) begin
				dotp = ex * vx[c] + ey * vy[c];
				cr   = ex * vy[c] - ey * vx[c];
				mag  = (cr < 0) ? longint'(-cr) : longint'(cr);
				mag  = mag >> 4;
				if (v2[c] != 0 && dotp > 0
					&& mag * mag * grc_pkg::EDGE_RATIO < (v2[c] << 20))
					hit_edge = 1'b1;
			end
		end
		return hit_edge;
	endfunction

	function automatic grc_pkg::res_t cast_column(logic [9:0] col);
		int unsigned w, ang;
		longint ex, ey, d, px, py, h, ceil_r;
		longint unsigned cx, cy;
		bit hit, hit_edge;
		grc_pkg::res_t r;
		w   = (view_width != 0) ? view_width : 1;
		ang = (view_heading + (int'(col) * view_fov) / w - (view_fov >> 1)) & 4095;
		ex  = sine_lookup(ang);
		ey  = sine_lookup((ang + 1024) & 4095);
		d = 0;
		hit = 1'b0;
		hit_edge = 1'b0;
		while (!hit && d < grc_pkg::DEPTH) begin
			d  = d + grc_pkg::MARCH_STEP;
			px = longint'(view_x) * 16384 + ex * d;
			py = longint'(view_y) * 16384 + ey * d;
			if (px < 0 || py < 0) begin
				hit = 1'b1;
				d = grc_pkg::DEPTH;
			end else begin
				cx = px >> 22;
				cy = py >> 22;
				if (cx >= grc_pkg::MAP_SIZE || cy >= grc_pkg::MAP_SIZE) begin
					hit = 1'b1;
					d = grc_pkg::DEPTH;
				end else if (map_rows[cx][cy]) begin
					hit = 1'b1;
					hit_edge = grazes_corner(cx, cy, ex, ey);
				end
			end
		end
		if (d > grc_pkg::DEPTH)
			d = grc_pkg::DEPTH;
		h = view_height;
		ceil_r = 0;
		if (d > 0) begin
			if (d >= 512)
				ceil_r = (h * (d - 512)) / (2 * d);
			else
				ceil_r = -((h * (512 - d)) / (2 * d));
		end
		if (ceil_r < -1)
			ceil_r = -1;
		r.column_out  = col;
		r.distance    = d[12:0];
		r.ceiling_row = ceil_r[10:0];
		r.floor_row   = 11'(h - ceil_r);
		if (4 * d <= grc_pkg::DEPTH)
			r.wall_shade = grc_pkg::SHADE_FULL;
		else if (3 * d < grc_pkg::DEPTH)
			r.wall_shade = grc_pkg::SHADE_DARK;
		else if (2 * d < grc_pkg::DEPTH)
			r.wall_shade = grc_pkg::SHADE_MEDIUM;
		else if (d < grc_pkg::DEPTH)
			r.wall_shade = grc_pkg::SHADE_LIGHT;
		else
			r.wall_shade = grc_pkg::SHADE_BLANK;
		if (hit_edge)
			r.wall_shade = grc_pkg::SHADE_BLANK;
		r.tile_edge = hit_edge;
		return r;
	endfunction

	task automatic report(string field, longint want, longint got);
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		errors++;
	endtask

	// Result side: random stall per word, compared in order of issue.
	int hold;
	always @(posedge clk) begin
		grc_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (column_q.size() == 0) begin
				$display("%0t: unexpected word, column %0d", $time, res.column_out);
				errors++;
			end else begin
				want = column_q.pop_front();
				casts_seen++;
				if (res.column_out !== want.column_out)
					report("column_out", want.column_out, res.column_out);
				if (res.distance !== want.distance)
					report("distance", want.distance, res.distance);
				if (res.ceiling_row !== want.ceiling_row)
					report("ceiling_row", want.ceiling_row, res.ceiling_row);
				if (res.floor_row !== want.floor_row)
					report("floor_row", want.floor_row, res.floor_row);
				if (res.wall_shade !== want.wall_shade)
					report("wall_shade", want.wall_shade, res.wall_shade);
				if (res.tile_edge !== want.tile_edge)
					report("tile_edge", want.tile_edge, res.tile_edge);
			end
			hold = quiet ? 0 : $urandom_range(0, 17);
		end else if (hold > 0) begin
			hold = hold - 1;
		end
		res_stall <= (hold > 0);
	end

	task automatic send_word(grc_pkg::cmd_t c);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		words_sent++;
		if (c.kind == grc_pkg::KIND_LOAD)
			map_rows[c.row_index] = c.row_bits;
		else
			column_q.insert(column_q.size(), cast_column(c.column));
	endtask

	task automatic load_row(int r, logic [31:0] bits);
		grc_pkg::cmd_t c;
		c.kind = grc_pkg::KIND_LOAD;
		c.row_index = r[4:0];
		c.row_bits = bits;
		c.column = 10'($urandom);
		send_word(c);
	endtask

	task automatic cast(int col);
		grc_pkg::cmd_t c;
		c.kind = grc_pkg::KIND_CAST;
		c.row_index = 5'($urandom);
		c.row_bits = $urandom;
		c.column = col[9:0];
		send_word(c);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (column_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_view(int px, int py, int hd, int fv, int w, int h);
		logic [2:0] idx [6];
		int val [6];
		idx = '{grc_pkg::CFG_PLAYER_X, grc_pkg::CFG_PLAYER_Y, grc_pkg::CFG_HEADING,
			grc_pkg::CFG_FOV, grc_pkg::CFG_WIDTH, grc_pkg::CFG_HEIGHT};
		val = '{px, py, hd, fv, w, h};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx[i])
				grc_pkg::CFG_PLAYER_X: view_x = val[i] & 32'h1FFF;
				grc_pkg::CFG_PLAYER_Y: view_y = val[i] & 32'h1FFF;
				grc_pkg::CFG_HEADING:  view_heading = val[i] & 32'hFFF;
				grc_pkg::CFG_FOV:      view_fov = val[i] & 32'hFFF;
				grc_pkg::CFG_WIDTH:    view_width = val[i] & 32'h3FF;
				default:               view_height = val[i] & 32'h3FF;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_open_floor();
		cast(0);
		cast(160);
		cast(319);
		cast(1023);
	endtask

	task automatic test_walled_room();
		load_row(0, 32'hFFFF_FFFF);
		load_row(31, 32'hFFFF_FFFF);
		for (int r = 1; r < 31; r++)
			load_row(r, 32'h8000_0001 | ((r == 12) ? 32'h0000_0300 : 32'h0));
		cast(0);
		cast(319);
		cast(500);
	endtask

	task automatic test_extremes();
		set_view(0, 0, 512, 1, 1, 1023);
		cast(0);
		cast(1023);
		set_view(8191, 8191, 2560, 2048, 1023, 1);
		cast(0);
		cast(1022);
		set_view(1290, 1290, 4095, 2048, 0, 0);
		cast(5);
		cast(0);
		// Player standing exactly on the corner of a wall tile.
		load_row(5, 32'h0000_0020);
		set_view(1280, 1280, 512, 64, 2, 240);
		cast(0);
		cast(1);
		set_view(300, 300, 0, 512, 320, 240);
		cast(100);
	endtask

	task automatic test_random_maps();
		int density;
		logic [31:0] bits;
		for (int ph = 0; ph < 9; ph++) begin
			quiet = (ph == 3);
			if (ph == 8)
				set_view(3763, 1303, 0, 512, 320, 240);
			else
				set_view($urandom_range(256, 7935), $urandom_range(256, 7935),
					$urandom_range(0, 4095), $urandom_range(1, 2048),
					$urandom_range(1, 1023), $urandom_range(1, 1023));
			density = $urandom_range(0, 3);
			for (int r = 0; r < grc_pkg::MAP_SIZE; r++) begin
				bits = $urandom;
				for (int k = 0; k < density; k++)
					bits &= $urandom;
				if (r == 0 || r == grc_pkg::MAP_SIZE - 1)
					bits = 32'hFFFF_FFFF;
				bits[0] = (density != 0) | bits[0];
				bits[31] = (density != 0) | bits[31];
				load_row(r, bits);
			end
			for (int i = 0; i < 140; i++) begin
				if ($urandom_range(0, 9) == 0)
					load_row($urandom_range(0, 31), $urandom);
				else if ($urandom_range(0, 4) == 0)
					cast($urandom_range(0, 1023));
				else
					cast($urandom_range(0, (view_width > 0) ? view_width - 1 : 0));
				if (ph == 5 && i == 70)
					drain();
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		casts_seen = 0;
		words_sent = 0;
		cycles = 0;
		hold = 0;
		quiet = 1'b0;
		for (int r = 0; r < grc_pkg::MAP_SIZE; r++)
			map_rows[r] = '0;
		view_x = 3763;
		view_y = 1303;
		view_heading = 0;
		view_fov = 512;
		view_width = 320;
		view_height = 240;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_open_floor();
		test_walled_room();
		test_extremes();
		test_random_maps();
		drain();

		$display("Sent %0d words and checked %0d column casts across open, walled,", words_sent,
			casts_seen);
		$display("random maze maps and extreme view settings, with random stalls on both sides.");
		if (errors == 0 && column_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d casts still outstanding", errors, column_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
